/* design/assert_macros.svh */
// Assertion macros shared by the hash engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NOW(label, clk, rst, cond)
`endif
`endif

/* design/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// SM3 package
// Types, constants and round functions shared by the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;

   localparam logic [255:0] SM3_IV = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned QUEUE_DEPTH = 4;

   // Work item passed from the front part to the compression back part.
   typedef struct packed {
      logic [511:0] block;
      logic         last;
   } blk_item_type;

   typedef enum logic [1:0] {
      FR_FILL,
      FR_PAD1,
      FR_PAD2
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_OUT
   } back_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage
`default_nettype wire

/* design/sm3_stream_if.sv */
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* design/sm3_hash_engine_top.sv */
// A full block is queued when its 64th byte is accepted; the digest's first
// word follows once the one or two padding blocks and every block still queued
// ahead have been compressed.
// Throughput: one byte per cycle while the front part fills and the block queue
// has room; the single round unit in the back part takes one block at a time.
// Reset: synchronous, active high; restores the initial vector, empties the queue.
// ----------------------------------------------------------------------------
// SM3 hash engine top level
// Streaming SM3 digest of a byte stream, eight words per message.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_engine_top
   import sm3_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sm3_req_if.sink    req,
   sm3_rsp_if.source  rsp
);
   blk_item_type  push_item, pop_item;
   logic          push_valid, push_ready, pop_valid, pop_ready;

   // The front part packs bytes into blocks and adds padding.
   sm3_front u_front (.clock, .reset, .req, .push_item, .push_valid, .push_ready);

   // The queue decouples byte intake from the compression rounds.
   sm3_queue u_queue (.clock, .reset, .push_item, .push_valid, .push_ready,
                      .pop_item, .pop_valid, .pop_ready);

   // The back part runs the rounds and sends each digest transaction.
   sm3_back u_back (.clock, .reset, .pop_item, .pop_valid, .pop_ready, .rsp);
endmodule
`default_nettype wire

/* design/sm3_front.sv */
// ----------------------------------------------------------------------------
// SM3 front part
// Collects bytes into blocks, pads the final block and pushes block items.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_front
   import sm3_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   sm3_req_if.sink           req,
   output blk_item_type      push_item,
   output logic              push_valid,
   input  wire logic         push_ready
);
   logic [511:0]     block_ff, block_in;
   logic [5:0]       count_ff, count_in;
   logic [60:0]      len_ff, len_in;
   front_state_type  state_ff, state_in;
   logic [63:0]      bits;

   assign bits = {len_ff, 3'b000};

   // Accept while filling and the block queue has room.
   always_comb begin
      req.ready = (state_ff == FR_FILL) && push_ready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_FILL: begin
            if (req.valid && req.ready && req.end_of_message) state_in = FR_PAD1;
         end
         FR_PAD1: begin
            if (push_ready) state_in = (count_ff < 6'd56) ? FR_FILL : FR_PAD2;
         end
         FR_PAD2: begin
            if (push_ready) state_in = FR_FILL;
         end
         default: state_in = FR_FILL;
      endcase
   end

   // Block assembly and push outputs.
   always_comb begin
      block_in   = block_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      push_valid = 1'b0;
      push_item.block = block_ff;
      push_item.last  = 1'b0;
      case (state_ff)
         FR_FILL: begin
            if (req.valid && req.ready) begin
               if (req.byte_valid) begin
                  block_in[511 - 8*count_ff -: 8] = req.data_byte;
                  len_in = len_ff + 61'd1;
                  count_in = count_ff + 6'd1;
               end
               if (req.byte_valid && count_ff == 6'd63) begin
                  push_valid = 1'b1;
                  push_item.block = block_in;
               end
            end
         end
         FR_PAD1: begin
            // Build the first padding block.
            block_in[511 - 8*count_ff -: 8] = PAD_BYTE;
            for (int i = 0; i < 64; i++) begin
               if (i > int'(count_ff)) block_in[511 - 8*i -: 8] = 8'h00;
            end
            if (count_ff < 6'd56) begin
               block_in[63:0] = bits;
               push_item.block = block_in;
               push_item.last  = 1'b1;
            end else begin
               push_item.block = block_in;
            end
            push_valid = 1'b1;
            if (push_ready) begin
               if (count_ff < 6'd56) begin
                  count_in = '0;
                  len_in   = '0;
               end
            end else begin
               block_in = block_ff;
            end
         end
         FR_PAD2: begin
            push_item.block = {448'd0, bits};
            push_item.last  = 1'b1;
            push_valid = 1'b1;
            if (push_ready) begin
               count_in = '0;
               len_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      if (reset) begin
         state_ff <= FR_FILL;
         count_ff <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end
endmodule
`default_nettype wire

/* design/sm3_queue.sv */
// ----------------------------------------------------------------------------
// SM3 block queue
// Small FIFO of block items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sm3_queue
   import sm3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire blk_item_type  push_item,
   input  wire logic          push_valid,
   output logic               push_ready,
   output blk_item_type       pop_item,
   output logic               pop_valid,
   input  wire logic          pop_ready
);
   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   blk_item_type    mem [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            do_push, do_pop;

   assign push_ready = (cnt_ff != (AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_item;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end

   `ASSERT_NOW(a_cnt_range, clock, reset, cnt_ff <= (AW+1)'(QUEUE_DEPTH))
   `ASSERT_IMPL(a_full_no_grow, clock, reset, !push_ready && !do_pop |=> !push_ready)
   `ASSERT_IMPL(a_empty_pop, clock, reset, cnt_ff == '0 |-> !do_pop)
endmodule
`default_nettype wire

/* design/sm3_back.sv */
// ----------------------------------------------------------------------------
// SM3 back part
// One compression round per cycle in the round state over a 16-word expansion window.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sm3_back
   import sm3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire blk_item_type  pop_item,
   input  wire logic          pop_valid,
   output logic               pop_ready,
   sm3_rsp_if.source          rsp
);
   back_state_type  state_ff, state_in;
   logic [255:0]    cv_ff;
   logic [255:0]    wv_ff;
   logic [511:0]    win_ff;
   logic [5:0]      rnd_ff;
   logic            last_ff;
   logic [2:0]      oidx_ff;
   logic [31:0]     a, b, c, d, e, f, g, h, w0, w4, wn, tj, a12, ss1, ss2, tt1, tt2;
   logic [31:0]     fv, gv;
   logic [255:0]    cv_new;

   always_comb begin
      {a, b, c, d, e, f, g, h} = wv_ff;
      w0  = win_ff[511:480];
      w4  = win_ff[383:352];
      wn  = p1(win_ff[511:480] ^ win_ff[287:256] ^ rotl(win_ff[95:64], 5'd15))
            ^ rotl(win_ff[415:384], 5'd7) ^ win_ff[191:160];
      tj  = rotl((rnd_ff < 6'd16) ? T_LOW : T_HIGH, rnd_ff[4:0]);
      fv  = (rnd_ff < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
      gv  = (rnd_ff < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
      a12 = rotl(a, 5'd12);
      ss1 = rotl(a12 + e + tj, 5'd7);
      ss2 = ss1 ^ a12;
      tt1 = fv + d + ss2 + (w0 ^ w4);
      tt2 = gv + h + ss1 + w0;
      cv_new = cv_ff ^ {tt1, a, rotl(b, 5'd9), c, p0(tt2), e, rotl(f, 5'd19), g};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (pop_valid) state_in = BK_ROUND;
         BK_ROUND: if (rnd_ff == 6'd63) state_in = last_ff ? BK_OUT : BK_IDLE;
         BK_OUT:   if (rsp.ready && oidx_ff == 3'd7) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = (state_ff == BK_IDLE);
      rsp.valid = (state_ff == BK_OUT);
      rsp.digest_word = cv_ff[255 - 32*oidx_ff -: 32];
      rsp.word_index  = oidx_ff;
      rsp.last_word   = (oidx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            win_ff  <= pop_item.block;
            wv_ff   <= cv_ff;
            last_ff <= pop_item.last;
            rnd_ff  <= '0;
         end
         BK_ROUND: begin
            win_ff <= {win_ff[479:0], wn};
            wv_ff  <= {tt1, a, rotl(b, 5'd9), c, p0(tt2), e, rotl(f, 5'd19), g};
            rnd_ff <= rnd_ff + 6'd1;
         end
         default: ;
      endcase
      if (reset) begin
         state_ff <= BK_IDLE;
         cv_ff    <= SM3_IV;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_ROUND && rnd_ff == 6'd63) cv_ff <= cv_new;
         if (state_ff == BK_OUT && rsp.ready) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) cv_ff <= SM3_IV;
         end
      end
   end

   `ASSERT_IMPL(a_out_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid)
   `ASSERT_IMPL(a_idx_zero, clock, reset, state_ff == BK_IDLE |-> oidx_ff == 3'd0)
   `ASSERT_IMPL(a_round_end, clock, reset, state_ff == BK_OUT |-> rnd_ff == 6'd0)
endmodule
`default_nettype wire
